@@ rtl/voxel_block_occupancy_count_macros.svh @@
// Assertion helpers for the voxel block occupancy counter.
// They expect signals named clock and reset in the scope of use.
`ifndef VOXEL_BLOCK_OCCUPANCY_COUNT_MACROS_SVH
`define VOXEL_BLOCK_OCCUPANCY_COUNT_MACROS_SVH

// same-cycle implication, off during reset
`define VBOC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vboc: same-cycle check failed");

// next-cycle implication, off during reset
`define VBOC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vboc: next-cycle check failed");

// next-cycle implication, live during reset
`define VBOC_ASSERT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("vboc: reset check failed");

`endif

@@ rtl/vboc_pkg.sv @@
`default_nettype none

package vboc_pkg;

   localparam int MAX_DIM_XY = 256;
   localparam int MAX_BLOCK  = 16;

   localparam int XY_W      = $clog2(MAX_DIM_XY);
   localparam int DIM_W     = XY_W + 1;
   localparam int ADDR_W    = 2 * XY_W;
   localparam int MEM_DEPTH = MAX_DIM_XY * MAX_DIM_XY;
   localparam int Z_W       = 16;
   localparam int IB_W      = $clog2(MAX_BLOCK);
   localparam int BLK_W     = 5;
   localparam int OUT_XY_W  = 8;
   localparam int VALUE_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 16;

   localparam int                 COUNT_W   = 13;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int RSP_DEPTH = 3;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SIZE_X  = 3'd0,
      REG_SIZE_Y  = 3'd1,
      REG_SIZE_Z  = 3'd2,
      REG_BLOCK_X = 3'd3,
      REG_BLOCK_Y = 3'd4,
      REG_BLOCK_Z = 3'd5
   } csr_index_type;

   // clamped image and block sizes
   typedef struct packed {
      logic [DIM_W-1:0] sx;
      logic [DIM_W-1:0] sy;
      logic [Z_W-1:0]   sz;
      logic [BLK_W-1:0] bx;
      logic [BLK_W-1:0] by;
      logic [BLK_W-1:0] bz;
   } geom_type;

   // one voxel on its way to the count update
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              first;
      logic              emit;
      logic              done;
      logic              nz;
      logic [XY_W-1:0]   bcol;
      logic [XY_W-1:0]   brow;
      logic [Z_W-1:0]    bslice;
   } vox_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [OUT_XY_W-1:0] out_x;
      logic [OUT_XY_W-1:0] out_y;
      logic [Z_W-1:0]      out_z;
      logic [COUNT_W-1:0]  max_count;
      logic                image_done;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/vboc_pos.sv @@
`default_nettype none

module vboc_pos import vboc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  geom_type           geom,
   input  logic               advance,
   input  logic [VALUE_W-1:0] voxel_value,
   output vox_type            vox
);

   logic [XY_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [Z_W-1:0]  slice_ff, slice_in;
   logic [IB_W-1:0] ibx_ff, ibx_in, iby_ff, iby_in, ibz_ff, ibz_in;
   logic [XY_W-1:0] bcol_ff, bcol_in, brow_ff, brow_in;
   logic [Z_W-1:0]  bslice_ff, bslice_in;

   logic end_x, end_y, end_z, wrap_x, wrap_y, wrap_z;

   always_comb begin
      end_x  = ({1'b0, col_ff} + DIM_W'(1)) >= geom.sx;
      end_y  = ({1'b0, row_ff} + DIM_W'(1)) >= geom.sy;
      end_z  = ({1'b0, slice_ff} + (Z_W+1)'(1)) >= {1'b0, geom.sz};
      wrap_x = ({1'b0, ibx_ff} + BLK_W'(1)) >= geom.bx;
      wrap_y = ({1'b0, iby_ff} + BLK_W'(1)) >= geom.by;
      wrap_z = ({1'b0, ibz_ff} + BLK_W'(1)) >= geom.bz;

      vox.addr   = {brow_ff, bcol_ff};
      vox.first  = (ibx_ff == '0) && (iby_ff == '0) && (ibz_ff == '0);
      vox.emit   = (end_x || wrap_x) && (end_y || wrap_y) && (end_z || wrap_z);
      vox.done   = end_x && end_y && end_z;
      vox.nz     = |voxel_value;
      vox.bcol   = bcol_ff;
      vox.brow   = brow_ff;
      vox.bslice = bslice_ff;
   end

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      slice_in  = slice_ff;
      ibx_in    = ibx_ff;
      iby_in    = iby_ff;
      ibz_in    = ibz_ff;
      bcol_in   = bcol_ff;
      brow_in   = brow_ff;
      bslice_in = bslice_ff;
      if (end_x) begin
         col_in  = '0;
         ibx_in  = '0;
         bcol_in = '0;
         if (end_y) begin
            row_in  = '0;
            iby_in  = '0;
            brow_in = '0;
            if (end_z) begin
               slice_in  = '0;
               ibz_in    = '0;
               bslice_in = '0;
            end else begin
               slice_in = slice_ff + Z_W'(1);
               if (wrap_z) begin
                  ibz_in    = '0;
                  bslice_in = bslice_ff + Z_W'(1);
               end else begin
                  ibz_in = ibz_ff + IB_W'(1);
               end
            end
         end else begin
            row_in = row_ff + XY_W'(1);
            if (wrap_y) begin
               iby_in  = '0;
               brow_in = brow_ff + XY_W'(1);
            end else begin
               iby_in = iby_ff + IB_W'(1);
            end
         end
      end else begin
         col_in = col_ff + XY_W'(1);
         if (wrap_x) begin
            ibx_in  = '0;
            bcol_in = bcol_ff + XY_W'(1);
         end else begin
            ibx_in = ibx_ff + IB_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         slice_ff  <= '0;
         ibx_ff    <= '0;
         iby_ff    <= '0;
         ibz_ff    <= '0;
         bcol_ff   <= '0;
         brow_ff   <= '0;
         bslice_ff <= '0;
      end else if (advance) begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         slice_ff  <= slice_in;
         ibx_ff    <= ibx_in;
         iby_ff    <= iby_in;
         ibz_ff    <= ibz_in;
         bcol_ff   <= bcol_in;
         brow_ff   <= brow_in;
         bslice_ff <= bslice_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/vboc_mem.sv @@
`default_nettype none

module vboc_mem import vboc_pkg::*; (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [COUNT_W-1:0] rd_data,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [COUNT_W-1:0] wr_data
);

   logic [COUNT_W-1:0] count_mem [MEM_DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= count_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/vboc_accum.sv @@
`default_nettype none

module vboc_accum import vboc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  vox_type            vox_in,
   input  logic [COUNT_W-1:0] rd_data,
   output logic               mem_we,
   output logic [ADDR_W-1:0]  mem_waddr,
   output logic [COUNT_W-1:0] mem_wdata,
   output logic               push,
   output rsp_type            push_data,
   output logic               busy
);

   logic               s1_valid_ff;
   vox_type            s1_ff;
   logic               fwd_ff, fwd_in;
   logic [COUNT_W-1:0] fwd_data_ff;
   logic [COUNT_W-1:0] max_ff, max_in;

   logic [COUNT_W-1:0] base, cnt, new_max;
   logic [COUNT_W:0]   sum;

   always_comb begin
      if (s1_ff.first) begin
         base = '0;
      end else if (fwd_ff) begin
         base = fwd_data_ff;
      end else begin
         base = rd_data;
      end
      sum     = {1'b0, base} + (COUNT_W+1)'(s1_ff.nz);
      cnt     = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
      new_max = (cnt > max_ff) ? cnt : max_ff;

      mem_we    = s1_valid_ff && !s1_ff.emit;
      mem_waddr = s1_ff.addr;
      mem_wdata = cnt;
      push      = s1_valid_ff && s1_ff.emit;

      push_data.count      = cnt;
      push_data.out_x      = OUT_XY_W'(s1_ff.bcol);
      push_data.out_y      = OUT_XY_W'(s1_ff.brow);
      push_data.out_z      = s1_ff.bslice;
      push_data.max_count  = new_max;
      push_data.image_done = s1_ff.done;

      // write lands at the same edge the next read is taken
      fwd_in = in_valid && mem_we && (vox_in.addr == s1_ff.addr);

      max_in = max_ff;
      if (push) begin
         max_in = s1_ff.done ? '0 : new_max;
      end
   end

   assign busy = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         max_ff      <= '0;
      end else begin
         s1_valid_ff <= in_valid;
         fwd_ff      <= fwd_in;
         max_ff      <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_ff <= vox_in;
      end
      fwd_data_ff <= cnt;
   end

endmodule

`default_nettype wire

@@ rtl/vboc_rsp_fifo.sv @@
`default_nettype none

module vboc_rsp_fifo import vboc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_type              push_data,
   input  logic                 pop_ready,
   output logic                 out_valid,
   output rsp_type              out_data,
   output logic [RSP_CNT_W-1:0] fill
);

   rsp_type              entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] fill_ff, fill_in;
   logic                 pop;

   always_comb begin
      out_valid = fill_ff != '0;
      out_data  = entry_ff[rd_ptr_ff];
      pop       = out_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + RSP_PTR_W'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + RSP_PTR_W'(1);
      end
      fill_in = fill_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   end

   assign fill = fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/voxel_block_occupancy_count.sv @@
// Counts nonzero voxels per block of a raster-order 3D image (x fastest, then y, then z)
// and sends one beat per finished block with its count, block coordinates, the running
// maximum and an end-of-image flag. Sustained rate is one voxel per cycle while req_ready
// is high: each voxel reads a 65536 x 13 partial-count RAM at accept and, unless it closes
// its block, writes the new count back in the cycle after, with a bypass when consecutive
// voxels hit the same entry. A result beat passes the update stage and waits in a three-beat queue;
// req_ready drops only while the queue fill plus an occupied update stage reaches three.
// The RAM needs no clearing pass: the first voxel of every block ignores the stored value.
// Program the size and block registers only while the block is idle.
`default_nettype none

module voxel_block_occupancy_count import vboc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [VALUE_W-1:0]   req_voxel_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COUNT_W-1:0]   rsp_count,
   output logic [OUT_XY_W-1:0]  rsp_out_x,
   output logic [OUT_XY_W-1:0]  rsp_out_y,
   output logic [Z_W-1:0]       rsp_out_z,
   output logic [COUNT_W-1:0]   rsp_max_count,
   output logic                 rsp_image_done,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);

   logic [DIM_W-1:0] size_x_ff, size_y_ff;
   logic [Z_W-1:0]   size_z_ff;
   logic [BLK_W-1:0] block_x_ff, block_y_ff, block_z_ff;

   geom_type             geom;
   vox_type              vox;
   rsp_type              push_data, out_data;
   logic                 accept, busy, push, mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [COUNT_W-1:0]   mem_wdata, rd_data;
   logic [RSP_CNT_W-1:0] fill;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff  <= DIM_W'(256);
         size_y_ff  <= DIM_W'(256);
         size_z_ff  <= Z_W'(256);
         block_x_ff <= BLK_W'(2);
         block_y_ff <= BLK_W'(2);
         block_z_ff <= BLK_W'(2);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SIZE_X:  size_x_ff  <= csr_wr_data[DIM_W-1:0];
            REG_SIZE_Y:  size_y_ff  <= csr_wr_data[DIM_W-1:0];
            REG_SIZE_Z:  size_z_ff  <= csr_wr_data[Z_W-1:0];
            REG_BLOCK_X: block_x_ff <= csr_wr_data[BLK_W-1:0];
            REG_BLOCK_Y: block_y_ff <= csr_wr_data[BLK_W-1:0];
            REG_BLOCK_Z: block_z_ff <= csr_wr_data[BLK_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize x, y and block sizes clamp
   always_comb begin
      geom.sx = (size_x_ff == '0) ? DIM_W'(1) :
                (size_x_ff > DIM_W'(MAX_DIM_XY)) ? DIM_W'(MAX_DIM_XY) : size_x_ff;
      geom.sy = (size_y_ff == '0) ? DIM_W'(1) :
                (size_y_ff > DIM_W'(MAX_DIM_XY)) ? DIM_W'(MAX_DIM_XY) : size_y_ff;
      geom.sz = (size_z_ff == '0) ? Z_W'(1) : size_z_ff;
      geom.bx = (block_x_ff == '0) ? BLK_W'(1) :
                (block_x_ff > BLK_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) : block_x_ff;
      geom.by = (block_y_ff == '0) ? BLK_W'(1) :
                (block_y_ff > BLK_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) : block_y_ff;
      geom.bz = (block_z_ff == '0) ? BLK_W'(1) :
                (block_z_ff > BLK_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) : block_z_ff;
   end

   assign req_ready = ((RSP_CNT_W+1)'(fill) + (RSP_CNT_W+1)'(busy))
                      <= (RSP_CNT_W+1)'(RSP_DEPTH - 1);
   assign accept    = req_valid && req_ready;

   vboc_pos u_pos (
      .clock       (clock),
      .reset       (reset),
      .geom        (geom),
      .advance     (accept),
      .voxel_value (req_voxel_value),
      .vox         (vox)
   );

   vboc_mem u_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (vox.addr),
      .rd_data (rd_data),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata)
   );

   vboc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .vox_in    (vox),
      .rd_data   (rd_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .push      (push),
      .push_data (push_data),
      .busy      (busy)
   );

   vboc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .fill      (fill)
   );

   assign rsp_count      = out_data.count;
   assign rsp_out_x      = out_data.out_x;
   assign rsp_out_y      = out_data.out_y;
   assign rsp_out_z      = out_data.out_z;
   assign rsp_max_count  = out_data.max_count;
   assign rsp_image_done = out_data.image_done;

endmodule

`default_nettype wire

@@ rtl/vboc_checker.sv @@
`default_nettype none
`include "voxel_block_occupancy_count_macros.svh"

module vboc_checker import vboc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [COUNT_W-1:0]   rsp_count,
   input logic [OUT_XY_W-1:0]  rsp_out_x,
   input logic [OUT_XY_W-1:0]  rsp_out_y,
   input logic [Z_W-1:0]       rsp_out_z,
   input logic [COUNT_W-1:0]   rsp_max_count,
   input logic                 rsp_image_done
);

   rsp_type rsp_beat;
   assign rsp_beat = {rsp_count, rsp_out_x, rsp_out_y, rsp_out_z, rsp_max_count, rsp_image_done};

   `VBOC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_beat))
   `VBOC_ASSERT_NOW(a_max_covers, rsp_valid, rsp_max_count >= rsp_count)
   `VBOC_ASSERT_RST(a_reset_empty, reset, !rsp_valid && req_ready)
   `VBOC_ASSERT_NOW(a_stall_cause, !req_ready, rsp_valid)

endmodule

bind voxel_block_occupancy_count vboc_checker u_vboc_checker (.*);

`default_nettype wire

@@ sim/tb_voxel_block_occupancy_count.sv @@
`timescale 1ns / 1ps

module tb_voxel_block_occupancy_count;
   import vboc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int ITEM_TARGET = 1700;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [VALUE_W-1:0]   req_voxel_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [COUNT_W-1:0]   rsp_count;
   logic [OUT_XY_W-1:0]  rsp_out_x;
   logic [OUT_XY_W-1:0]  rsp_out_y;
   logic [Z_W-1:0]       rsp_out_z;
   logic [COUNT_W-1:0]   rsp_max_count;
   logic                 rsp_image_done;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wr_data = '0;

   voxel_block_occupancy_count uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_voxel_value (req_voxel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_count       (rsp_count),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_max_count   (rsp_max_count),
      .rsp_image_done  (rsp_image_done),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // geometry shadow, reset values
   logic [8:0]  geo_sx = 9'd256;
   logic [8:0]  geo_sy = 9'd256;
   logic [15:0] geo_sz = 16'd256;
   logic [4:0]  geo_bx = 5'd2;
   logic [4:0]  geo_by = 5'd2;
   logic [4:0]  geo_bz = 5'd2;

   // raster position and per-slab tallies
   logic [12:0] tally_ram [0:MEM_DEPTH-1];
   logic [7:0]  pos_col = '0;
   logic [7:0]  pos_row = '0;
   logic [15:0] pos_slice = '0;
   logic [3:0]  ib_x = '0;
   logic [3:0]  ib_y = '0;
   logic [3:0]  ib_z = '0;
   logic [7:0]  blk_col = '0;
   logic [7:0]  blk_row = '0;
   logic [15:0] blk_slice = '0;
   logic [12:0] peak = '0;

   rsp_type     due_counts [$];
   logic [31:0] voxel_queue [$];

   int voxels_queued = 0;
   int voxels_in = 0;
   int counts_checked = 0;
   int images_closed = 0;
   int geometry_writes = 0;
   int fail_count = 0;
   int cycle_count = 0;

   logic send_calm = 1'b0;
   logic recv_calm = 1'b0;
   logic hold_arm = 1'b0;
   logic hold_arm_q = 1'b0;
   int   hold_left = 0;
   int   send_gap = 0;
   int   recv_gap = 0;

   function automatic int clamp_dim(input int v, input int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   task automatic count_voxel(input logic [31:0] value);
      int          sx, sy, sz, bx, by, bz, tally;
      logic [15:0] addr;
      logic        first, end_x, end_y, end_z, close_blk;
      rsp_type     r;
      sx = clamp_dim(int'(geo_sx), MAX_DIM_XY);
      sy = clamp_dim(int'(geo_sy), MAX_DIM_XY);
      sz = clamp_dim(int'(geo_sz), 65535);
      bx = clamp_dim(int'(geo_bx), MAX_BLOCK);
      by = clamp_dim(int'(geo_by), MAX_BLOCK);
      bz = clamp_dim(int'(geo_bz), MAX_BLOCK);
      addr = {blk_row, blk_col};
      first = (ib_x == 0) && (ib_y == 0) && (ib_z == 0);
      end_x = pos_col + 1 >= sx;
      end_y = pos_row + 1 >= sy;
      end_z = pos_slice + 1 >= sz;
      close_blk = (end_x || ib_x + 1 >= bx) && (end_y || ib_y + 1 >= by)
                  && (end_z || ib_z + 1 >= bz);
      tally = (first ? 0 : int'(tally_ram[addr])) + int'(value != 0);
      if (tally > COUNT_MAX) tally = int'(COUNT_MAX);

      if (close_blk) begin
         if (tally > peak) peak = COUNT_W'(tally);
         r.count = COUNT_W'(tally);
         r.out_x = blk_col;
         r.out_y = blk_row;
         r.out_z = blk_slice;
         r.max_count = peak;
         r.image_done = end_x && end_y && end_z;
         due_counts.push_back(r);
      end else begin
         tally_ram[addr] = COUNT_W'(tally);
      end

      if (end_x) begin
         pos_col = 0; ib_x = 0; blk_col = 0;
         if (end_y) begin
            pos_row = 0; ib_y = 0; blk_row = 0;
            if (end_z) begin
               pos_slice = 0; ib_z = 0; blk_slice = 0;
               peak = 0;
            end else begin
               pos_slice++;
               if (ib_z + 1 >= bz) begin
                  ib_z = 0;
                  blk_slice++;
               end else ib_z++;
            end
         end else begin
            pos_row++;
            if (ib_y + 1 >= by) begin
               ib_y = 0;
               blk_row++;
            end else ib_y++;
         end
      end else begin
         pos_col++;
         if (ib_x + 1 >= bx) begin
            ib_x = 0;
            blk_col++;
         end else ib_x++;
      end
   endtask

   function automatic string show(input rsp_type r);
      return $sformatf("count=%0d x=%0d y=%0d z=%0d max=%0d done=%0b",
                       r.count, r.out_x, r.out_y, r.out_z, r.max_count, r.image_done);
   endfunction

   task automatic flag(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", msg);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (voxel_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_voxel_value <= voxel_queue.pop_front();
            send_gap <= send_calm ? 0 : $urandom_range(0, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      hold_arm_q <= hold_arm;
      if (reset) hold_left <= 0;
      else if (hold_arm && !hold_arm_q) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // receiver
   always @(posedge clock) begin : rsp_side
      int gap_n;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         gap_n = recv_calm ? 0 : $urandom_range(0, 9);
         recv_gap <= gap_n;
         rsp_ready <= (gap_n == 0);
      end else if (recv_gap != 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= (recv_gap == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: predict on each voxel beat, check each result beat
   always @(posedge clock) begin : observe
      rsp_type got, want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            count_voxel(req_voxel_value);
            voxels_in++;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_count, rsp_out_x, rsp_out_y, rsp_out_z, rsp_max_count, rsp_image_done};
            counts_checked++;
            if (got.image_done) images_closed++;
            if (due_counts.size() == 0) begin
               flag($sformatf("unexpected beat %s", show(got)));
            end else begin
               want = due_counts.pop_front();
               if (got !== want)
                  flag($sformatf("expected %s, got %s", show(want), show(got)));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      geometry_writes++;
      case (idx)
         REG_SIZE_X:  geo_sx = val[8:0];
         REG_SIZE_Y:  geo_sy = val[8:0];
         REG_SIZE_Z:  geo_sz = val;
         REG_BLOCK_X: geo_bx = val[4:0];
         REG_BLOCK_Y: geo_by = val[4:0];
         REG_BLOCK_Z: geo_bz = val[4:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(input int sx, sy, sz, bx, by, bz);
      write_reg(REG_SIZE_X, 16'(sx));
      write_reg(REG_SIZE_Y, 16'(sy));
      write_reg(REG_SIZE_Z, 16'(sz));
      write_reg(REG_BLOCK_X, 16'(bx));
      write_reg(REG_BLOCK_Y, 16'(by));
      write_reg(REG_BLOCK_Z, 16'(bz));
      end_writes();
   endtask

   task automatic set_pace(input logic s, input logic r);
      @(posedge clock);
      send_calm <= s;
      recv_calm <= r;
   endtask

   function automatic logic [31:0] pick_voxel(input int density);
      if ($urandom_range(0, 99) >= density) return '0;
      case ($urandom_range(0, 3))
         0: return 32'h1 << $urandom_range(0, 31);
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_image(input int n, input int density);
      @(negedge clock);
      for (int i = 0; i < n; i++) voxel_queue.push_back(pick_voxel(density));
      voxels_queued += n;
   endtask

   task automatic queue_list(input logic [31:0] vals [$]);
      @(negedge clock);
      foreach (vals[i]) voxel_queue.push_back(vals[i]);
      voxels_queued += vals.size();
   endtask

   // wait until every beat is in and every count is out, then let the pipe settle
   task automatic drain();
      do @(negedge clock);
      while (voxel_queue.size() != 0 || req_valid || due_counts.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic int rand_size(input int hi);
      return ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, hi);
   endfunction

   function automatic int rand_block();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(17, 31);
      return $urandom_range(1, 6);
   endfunction

   initial begin
      int rx, ry, rz, kx, ky, kz, n, density;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // clipped 3x2x2 image, value extremes
      configure(3, 2, 2, 2, 2, 2);
      queue_list('{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF,
                   32'h1, 32'h0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0});
      drain();

      // zero sizes and blocks act as one: every voxel is a whole image
      configure(0, 0, 0, 0, 0, 0);
      queue_list('{32'h1, 32'h0, 32'hFFFF_FFFF});
      drain();

      // oversized blocks clamp to the max block
      configure(5, 4, 3, 31, 17, 20);
      queue_image(60, 70);
      drain();

      // oversized width clamps to the max dimension
      set_pace(1'b1, 1'b0);
      configure(511, 1, 1, 1, 1, 1);
      queue_image(256, 50);
      drain();

      configure(1, 256, 1, 1, 1, 1);
      queue_image(256, 50);
      drain();

      set_pace(1'b0, 1'b1);
      configure(32, 2, 1, 16, 1, 2);
      queue_image(64, 80);
      drain();

      // geometry changed mid-image along z only
      configure(1, 1, 65535, 1, 1, 3);
      queue_image(10, 60);
      drain();
      write_reg(REG_BLOCK_Z, 16);
      end_writes();
      queue_image(20, 60);
      drain();
      write_reg(REG_SIZE_Z, 0);
      end_writes();
      queue_image(1, 100);
      drain();

      // receiver holds off while the sender keeps offering
      configure(8, 8, 2, 1, 1, 1);
      set_pace(1'b1, 1'b0);
      @(posedge clock);
      hold_arm <= 1'b1;
      queue_image(128, 60);
      drain();
      @(posedge clock);
      hold_arm <= 1'b0;

      while (voxels_queued < ITEM_TARGET) begin
         rx = rand_size(12);
         ry = rand_size(8);
         rz = rand_size(5);
         kx = rand_block();
         ky = rand_block();
         kz = rand_block();
         configure(rx, ry, rz, kx, ky, kz);
         set_pace($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
         n = clamp_dim(rx, MAX_DIM_XY) * clamp_dim(ry, MAX_DIM_XY) * clamp_dim(rz, 65535);
         case ($urandom_range(0, 3))
            0: density = 10;
            1: density = 50;
            2: density = 90;
            default: density = 100;
         endcase
         queue_image(n * $urandom_range(1, 3), density);
         drain();
      end

      repeat (20) @(posedge clock);
      $display("summary: %0d voxels in, %0d block counts checked, %0d images closed",
               voxels_in, counts_checked, images_closed);
      $display("summary: %0d register writes, %0d mismatches", geometry_writes, fail_count);
      if (fail_count == 0 && due_counts.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
